[rtl/core/mck_pkg.sv]
package mck_pkg;

    localparam int TICK_BITS   = 16;
    localparam int ROM_DEPTH   = 59;
    localparam int ROM_IDX_W   = 6;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd90;
    localparam logic [7:0] LOWER_FIRST  = 8'd97;
    localparam logic [7:0] LOWER_LAST   = 8'd122;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [ROM_IDX_W-1:0] UNKNOWN_IDX = 6'd31;

    localparam logic [2:0] UNITS_DOT   = 3'd1;
    localparam logic [2:0] UNITS_GAP   = 3'd1;
    localparam logic [2:0] UNITS_DASH  = 3'd3;
    localparam logic [2:0] UNITS_CLOSE = 3'd3;
    localparam logic [2:0] UNITS_SPACE = 3'd7;

    typedef struct packed {
        logic [2:0] count;
        logic [5:0] pattern;
    } t_entry;

    typedef struct packed {
        logic       mode;
        t_entry     entry;
    } t_item;

    typedef struct packed {
        logic lamp_on;
        logic busy_res;
        logic char_done;
        logic accepted;
    } t_result;

    // element count in the top bits, first element in the highest count bit, 1 = dash
    localparam logic [8:0] MORSE_ROM [ROM_DEPTH] = '{
        {3'd0, 6'd0},  {3'd6, 6'd43}, {3'd6, 6'd18}, {3'd6, 6'd12},
        {3'd6, 6'd12}, {3'd6, 6'd12}, {3'd5, 6'd8},  {3'd6, 6'd30},
        {3'd5, 6'd22}, {3'd6, 6'd45}, {3'd6, 6'd12}, {3'd5, 6'd10},
        {3'd6, 6'd51}, {3'd6, 6'd33}, {3'd6, 6'd21}, {3'd5, 6'd18},
        {3'd5, 6'd31}, {3'd5, 6'd15}, {3'd5, 6'd7},  {3'd5, 6'd3},
        {3'd5, 6'd1},  {3'd5, 6'd0},  {3'd5, 6'd16}, {3'd5, 6'd24},
        {3'd5, 6'd28}, {3'd5, 6'd30}, {3'd6, 6'd56}, {3'd6, 6'd12},
        {3'd6, 6'd12}, {3'd5, 6'd17}, {3'd6, 6'd12}, {3'd6, 6'd12},
        {3'd6, 6'd26}, {3'd2, 6'd1},  {3'd4, 6'd8},  {3'd4, 6'd10},
        {3'd3, 6'd4},  {3'd1, 6'd0},  {3'd4, 6'd2},  {3'd3, 6'd6},
        {3'd4, 6'd0},  {3'd2, 6'd0},  {3'd4, 6'd7},  {3'd3, 6'd5},
        {3'd4, 6'd4},  {3'd2, 6'd3},  {3'd2, 6'd2},  {3'd3, 6'd7},
        {3'd4, 6'd6},  {3'd4, 6'd13}, {3'd3, 6'd2},  {3'd3, 6'd0},
        {3'd1, 6'd1},  {3'd3, 6'd1},  {3'd4, 6'd1},  {3'd3, 6'd3},
        {3'd4, 6'd9},  {3'd4, 6'd11}, {3'd4, 6'd12}
    };

    function automatic t_entry morse_lookup(input logic [7:0] ch);
        logic [7:0]           folded;
        logic [ROM_IDX_W-1:0] idx;
        folded = ch;
        if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
            folded = ch - CASE_OFFSET;
        end
        if (folded < CHAR_FIRST || folded > CHAR_LAST) begin
            idx = UNKNOWN_IDX;
        end else begin
            idx = ROM_IDX_W'(folded - CHAR_FIRST);
        end
        return t_entry'(MORSE_ROM[idx]);
    endfunction

endpackage

[rtl/core/mck_in_if.sv]
interface mck_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] ascii_char;

    modport source (output valid, output mode, output ascii_char, input ready);
    modport sink   (input valid, input mode, input ascii_char, output ready);
endinterface

[rtl/core/mck_out_if.sv]
interface mck_out_if;
    logic valid;
    logic ready;
    logic lamp_on;
    logic busy_res;
    logic char_done;
    logic accepted;

    modport source (output valid, output lamp_on, output busy_res, output char_done,
                    output accepted, input ready);
    modport sink   (input valid, input lamp_on, input busy_res, input char_done,
                    input accepted, output ready);
endinterface

[rtl/core/mck_front.sv]
module mck_front (
    mck_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output mck_pkg::t_item  o_item
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // classify and look up the pattern now; the back end ignores it for ticks
    always_comb begin
        o_item.mode  = i_in.mode;
        o_item.entry = mck_pkg::morse_lookup(i_in.ascii_char);
    end

endmodule

[rtl/core/mck_queue.sv]
module mck_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mck_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mck_pkg::t_item  o_item
);

    mck_pkg::t_item                 r_mem [mck_pkg::Q_DEPTH];
    logic [mck_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [mck_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [mck_pkg::Q_CNT_W-1:0]    r_count;

    assign o_full  = (r_count == mck_pkg::Q_CNT_W'(mck_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/mck_back.sv]
module mck_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mck_pkg::TICK_BITS-1:0]   i_ticks_per_unit,
    input  logic                            i_valid,
    input  mck_pkg::t_item                  i_item,
    output logic                            o_pop,
    mck_out_if.source                       o_out
);

    logic                           r_active, n_active;
    logic                           r_closing, n_closing;
    logic                           r_lamp, n_lamp;
    logic [3:0]                     r_pos, n_pos;
    logic [2:0]                     r_units, n_units;
    logic [mck_pkg::TICK_BITS-1:0]  r_ticks, n_ticks;
    mck_pkg::t_entry                r_entry, n_entry;
    logic                           r_out_valid;
    mck_pkg::t_result               r_out;

    logic [mck_pkg::TICK_BITS-1:0]  unit_ticks;
    mck_pkg::t_entry                slot_entry;
    logic [3:0]                     slot_pos;
    logic                           slot_closing;
    logic                           slot_lamp;
    logic [2:0]                     slot_units;
    logic [3:0]                     slot_last;
    logic [2:0]                     slot_idx;
    logic [7:0]                     slot_bits;
    logic                           do_load;
    logic                           done;
    logic                           acc;

    assign unit_ticks = (i_ticks_per_unit == '0) ? mck_pkg::TICK_BITS'(1) : i_ticks_per_unit;
    assign o_pop      = i_valid && (!r_out_valid || o_out.ready);

    // a start loads the first slot of the new entry, a tick the slot after the current one
    assign slot_entry = (i_item.mode == mck_pkg::MODE_START) ? i_item.entry : r_entry;
    assign slot_pos   = (i_item.mode == mck_pkg::MODE_START) ? 4'd0 : r_pos + 4'd1;

    // decode what the slot at slot_pos starts: mark, gap, space or closing gap
    always_comb begin
        slot_last    = {slot_entry.count, 1'b0} - 4'd1;
        slot_idx     = slot_entry.count - 3'd1 - slot_pos[3:1];
        slot_bits    = {2'b00, slot_entry.pattern};
        slot_closing = 1'b0;
        slot_lamp    = 1'b0;
        slot_units   = mck_pkg::UNITS_GAP;
        if (slot_entry.count == '0) begin
            slot_closing = (slot_pos != '0);
            slot_units   = (slot_pos == '0) ? mck_pkg::UNITS_SPACE : mck_pkg::UNITS_CLOSE;
        end else if (slot_pos >= slot_last) begin
            slot_closing = 1'b1;
            slot_units   = mck_pkg::UNITS_CLOSE;
        end else if (!slot_pos[0]) begin
            slot_lamp  = 1'b1;
            slot_units = slot_bits[slot_idx] ? mck_pkg::UNITS_DASH : mck_pkg::UNITS_DOT;
        end
    end

    always_comb begin
        n_active   = r_active;
        n_closing  = r_closing;
        n_lamp     = r_lamp;
        n_pos      = r_pos;
        n_units    = r_units;
        n_ticks    = r_ticks;
        n_entry    = r_entry;
        do_load    = 1'b0;
        done       = 1'b0;
        acc        = 1'b0;
        if (i_item.mode == mck_pkg::MODE_START) begin
            if (!r_active) begin
                acc        = 1'b1;
                n_active   = 1'b1;
                n_entry    = i_item.entry;
                n_pos      = '0;
                do_load    = 1'b1;
            end
        end else if (r_active) begin
            if (r_ticks > mck_pkg::TICK_BITS'(1)) begin
                n_ticks = r_ticks - 1'b1;
            end else begin
                n_ticks = unit_ticks;
                if (r_units > 3'd1) begin
                    n_units = r_units - 1'b1;
                end else if (r_closing) begin
                    n_active  = 1'b0;
                    n_closing = 1'b0;
                    n_lamp    = 1'b0;
                    n_units   = '0;
                    n_ticks   = '0;
                    done      = 1'b1;
                end else begin
                    n_pos   = slot_pos;
                    do_load = 1'b1;
                end
            end
        end
        if (do_load) begin
            n_lamp    = slot_lamp;
            n_units   = slot_units;
            n_ticks   = unit_ticks;
            n_closing = slot_closing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_closing   <= 1'b0;
            r_lamp      <= 1'b0;
            r_pos       <= '0;
            r_units     <= '0;
            r_ticks     <= '0;
            r_entry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active    <= n_active;
                r_closing   <= n_closing;
                r_lamp      <= n_lamp;
                r_pos       <= n_pos;
                r_units     <= n_units;
                r_ticks     <= n_ticks;
                r_entry     <= n_entry;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.lamp_on   <= n_lamp;
            r_out.busy_res  <= n_active;
            r_out.char_done <= done;
            r_out.accepted  <= acc;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.lamp_on   = r_out.lamp_on;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.char_done = r_out.char_done;
    assign o_out.accepted  = r_out.accepted;

endmodule

[rtl/core/morse_character_keyer_core.sv]
// ITU Morse keyer. Each input transfer is either a character start (mode 0) or one
// timebase tick (mode 1), and each gives exactly one result transfer carrying the lamp
// level, busy flag, completion pulse and whether the start was taken. A start while
// busy is answered with accepted = 0 and changes nothing. The block takes one item per
// clock while its queue is not full: the front end looks up the pattern in a 59-entry
// ROM as the item arrives, a two-entry queue carries it to the back end, and the back
// end updates the element sequencer and its tick and unit counters into an output
// register, so results leave one per cycle while the sink keeps ready high. The user
// must write ticks_per_unit through i_cfg_wr_en and i_cfg_wr_data only while idle;
// the block does not enforce this. A value of zero counts as one tick.
module morse_character_keyer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mck_pkg::TICK_BITS-1:0]   i_cfg_wr_data,
    mck_in_if.sink                          i_in,
    mck_out_if.source                       o_out
);

    logic [mck_pkg::TICK_BITS-1:0]  r_ticks_per_unit;
    logic                           w_push;
    logic                           w_full;
    logic                           w_pop;
    logic                           w_q_valid;
    mck_pkg::t_item                 w_push_item;
    mck_pkg::t_item                 w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= mck_pkg::TICK_BITS'(200);
        end else if (i_cfg_wr_en) begin
            r_ticks_per_unit <= i_cfg_wr_data;
        end
    end

    mck_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    mck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    mck_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ticks_per_unit (r_ticks_per_unit),
        .i_valid          (w_q_valid),
        .i_item           (w_q_item),
        .o_pop            (w_pop),
        .o_out            (o_out)
    );

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_done) |-> !o_out.busy_res)
        else $error("completion pulse while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> o_out.busy_res)
        else $error("accepted start without going busy");

    a_lamp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.lamp_on) |-> o_out.busy_res)
        else $error("lamp on while idle");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> !w_full)
        else $error("queue still full after a pop");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT       = 300;
    localparam int IDLE_PCT      = 21;
    localparam int LONGEST_CHAR  = 22;

    // count in the top three bits, first element in the highest count bit, 1 = dash
    localparam logic [8:0] CODE_TABLE [59] = '{
        {3'd0, 6'd0},  {3'd6, 6'd43}, {3'd6, 6'd18}, {3'd6, 6'd12},
        {3'd6, 6'd12}, {3'd6, 6'd12}, {3'd5, 6'd8},  {3'd6, 6'd30},
        {3'd5, 6'd22}, {3'd6, 6'd45}, {3'd6, 6'd12}, {3'd5, 6'd10},
        {3'd6, 6'd51}, {3'd6, 6'd33}, {3'd6, 6'd21}, {3'd5, 6'd18},
        {3'd5, 6'd31}, {3'd5, 6'd15}, {3'd5, 6'd7},  {3'd5, 6'd3},
        {3'd5, 6'd1},  {3'd5, 6'd0},  {3'd5, 6'd16}, {3'd5, 6'd24},
        {3'd5, 6'd28}, {3'd5, 6'd30}, {3'd6, 6'd56}, {3'd6, 6'd12},
        {3'd6, 6'd12}, {3'd5, 6'd17}, {3'd6, 6'd12}, {3'd6, 6'd12},
        {3'd6, 6'd26}, {3'd2, 6'd1},  {3'd4, 6'd8},  {3'd4, 6'd10},
        {3'd3, 6'd4},  {3'd1, 6'd0},  {3'd4, 6'd2},  {3'd3, 6'd6},
        {3'd4, 6'd0},  {3'd2, 6'd0},  {3'd4, 6'd7},  {3'd3, 6'd5},
        {3'd4, 6'd4},  {3'd2, 6'd3},  {3'd2, 6'd2},  {3'd3, 6'd7},
        {3'd4, 6'd6},  {3'd4, 6'd13}, {3'd3, 6'd2},  {3'd3, 6'd0},
        {3'd1, 6'd1},  {3'd3, 6'd1},  {3'd4, 6'd1},  {3'd3, 6'd3},
        {3'd4, 6'd9},  {3'd4, 6'd11}, {3'd4, 6'd12}
    };

    typedef struct packed {
        logic        is_cfg;
        logic        mode;
        logic [7:0]  ch;
        logic [15:0] value;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;

    mck_in_if  in_bus ();
    mck_out_if out_bus ();

    morse_character_keyer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    t_pending          key_items [$];
    mck_pkg::t_result  results_due [$];

    // keyer state as the predictor sees it
    logic [15:0] unit_cfg = 16'd200;
    logic        keying = 1'b0;
    logic [5:0]  rom_row = 6'd0;
    logic [3:0]  slot = 4'd0;
    logic [2:0]  units_left = 3'd0;
    logic [15:0] ticks_left = 16'd0;
    logic        lamp_lvl = 1'b0;
    logic        in_tail = 1'b0;

    int errors = 0;
    int sent_count = 0;
    int res_count = 0;
    int settle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [5:0] row_of(logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= mck_pkg::LOWER_FIRST && c <= mck_pkg::LOWER_LAST) begin
            c = c - mck_pkg::CASE_OFFSET;
        end
        if (c < mck_pkg::CHAR_FIRST || c > mck_pkg::CHAR_LAST) begin
            return mck_pkg::UNKNOWN_IDX;
        end
        return 6'(c - mck_pkg::CHAR_FIRST);
    endfunction

    function automatic logic [15:0] unit_len();
        return (unit_cfg == 16'd0) ? 16'd1 : unit_cfg;
    endfunction

    function automatic void start_period(logic on, logic [2:0] units);
        lamp_lvl   = on;
        units_left = units;
        ticks_left = unit_len();
    endfunction

    // set up the mark, gap or closing gap that belongs at the current slot
    function automatic void load_element();
        logic [8:0] entry;
        int         cnt;
        int         k;
        entry = CODE_TABLE[rom_row];
        cnt   = int'(entry[8:6]);
        if (cnt == 0) begin
            if (slot == 4'd0) begin
                start_period(1'b0, mck_pkg::UNITS_SPACE);
            end else begin
                in_tail = 1'b1;
                start_period(1'b0, mck_pkg::UNITS_CLOSE);
            end
        end else if (int'(slot) >= 2 * cnt - 1) begin
            in_tail = 1'b1;
            start_period(1'b0, mck_pkg::UNITS_CLOSE);
        end else if (slot[0]) begin
            start_period(1'b0, mck_pkg::UNITS_GAP);
        end else begin
            k = int'(slot >> 1);
            start_period(1'b1, entry[cnt - 1 - k] ? mck_pkg::UNITS_DASH : mck_pkg::UNITS_DOT);
        end
    endfunction

    function automatic mck_pkg::t_result keyer_next(logic mode, logic [7:0] ch);
        mck_pkg::t_result r;
        r = '0;
        if (mode == mck_pkg::MODE_START) begin
            if (!keying) begin
                r.accepted = 1'b1;
                keying     = 1'b1;
                in_tail    = 1'b0;
                slot       = 4'd0;
                rom_row    = row_of(ch);
                load_element();
            end
        end else if (keying) begin
            if (ticks_left > 16'd1) begin
                ticks_left = ticks_left - 16'd1;
            end else begin
                ticks_left = unit_len();
                if (units_left > 3'd1) begin
                    units_left = units_left - 3'd1;
                end else if (in_tail) begin
                    keying      = 1'b0;
                    in_tail     = 1'b0;
                    lamp_lvl    = 1'b0;
                    units_left  = 3'd0;
                    ticks_left  = 16'd0;
                    r.char_done = 1'b1;
                end else begin
                    slot = slot + 4'd1;
                    load_element();
                end
            end
        end
        r.lamp_on  = lamp_lvl;
        r.busy_res = keying;
        return r;
    endfunction

    // total units from start to completion pulse
    function automatic int char_length_units(logic [7:0] ch);
        logic [8:0] entry;
        int         cnt;
        int         total;
        entry = CODE_TABLE[row_of(ch)];
        cnt   = int'(entry[8:6]);
        if (cnt == 0) begin
            return mck_pkg::UNITS_SPACE + mck_pkg::UNITS_CLOSE;
        end
        total = cnt - 1 + mck_pkg::UNITS_CLOSE;
        for (int k = 0; k < cnt; k++) begin
            total += entry[k] ? mck_pkg::UNITS_DASH : mck_pkg::UNITS_DOT;
        end
        return total;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'($urandom_range(90, 65));
        if (r < 60) return 8'($urandom_range(122, 97));
        if (r < 75) return 8'($urandom_range(64, 33));
        if (r < 80) return " ";
        return 8'($urandom_range(255));
    endfunction

    task automatic push_item(logic mode, logic [7:0] ch);
        t_pending p;
        p        = '0;
        p.mode   = mode;
        p.ch     = ch;
        key_items.push_back(p);
    endtask

    task automatic push_tick();
        push_item(mck_pkg::MODE_TICK, 8'($urandom));
    endtask

    task automatic push_setting(logic [15:0] value);
        t_pending p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.value  = value;
        key_items.push_back(p);
    endtask

    // one character keyed out by ticks, with stray starts and now and then cut short
    task automatic add_char_run(int len);
        logic [7:0] ch;
        int         n;
        ch = pick_char();
        push_item(mck_pkg::MODE_START, ch);
        n = char_length_units(ch) * len;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(n - 1);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 6) begin
                push_item(mck_pkg::MODE_START, pick_char());
            end
            push_tick();
        end
        repeat ($urandom_range(2)) push_tick();
    endtask

    task automatic run_phase(logic [15:0] setting, int count);
        int len;
        int first;
        push_setting(setting);
        len   = (setting == 16'd0) ? 1 : int'(setting);
        first = key_items.size();
        while (key_items.size() - first < count) begin
            add_char_run(len);
        end
        // flush any character left running before the next write
        repeat (LONGEST_CHAR * len + 2) push_tick();
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_pending head;
        logic     take;
        logic     next_valid;
        logic     next_wr;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            cfg_wr_en    <= 1'b0;
        end else begin
            take       = in_bus.valid && in_bus.ready;
            next_valid = in_bus.valid && !take;
            next_wr    = 1'b0;
            if (take) begin
                results_due.push_back(keyer_next(in_bus.mode, in_bus.ascii_char));
                sent_count++;
            end
            if (!in_bus.valid && results_due.size() == 0) begin
                settle++;
            end else begin
                settle = 0;
            end
            if (!next_valid && key_items.size() > 0) begin
                head = key_items[0];
                if (head.is_cfg) begin
                    // write only once the block has drained
                    if (settle >= SETTLE_CYCLES) begin
                        void'(key_items.pop_front());
                        next_wr = 1'b1;
                        cfg_wr_data <= head.value;
                        unit_cfg = head.value;
                        settle   = 0;
                    end
                end else if ((sent_count >= 100 && sent_count < 200) ||
                             $urandom_range(99) >= IDLE_PCT) begin
                    void'(key_items.pop_front());
                    next_valid = 1'b1;
                    in_bus.mode       <= head.mode;
                    in_bus.ascii_char <= head.ch;
                end
            end
            in_bus.valid <= next_valid;
            cfg_wr_en    <= next_wr;
        end
    end

    always @(posedge i_clk) begin : check_proc
        mck_pkg::t_result want;
        logic             next_ready;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                res_count++;
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (out_bus.lamp_on !== want.lamp_on) begin
                        $error("lamp_on: expected %0b, got %0b", want.lamp_on, out_bus.lamp_on);
                        errors++;
                    end
                    if (out_bus.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, out_bus.busy_res);
                        errors++;
                    end
                    if (out_bus.char_done !== want.char_done) begin
                        $error("char_done: expected %0b, got %0b",
                               want.char_done, out_bus.char_done);
                        errors++;
                    end
                    if (out_bus.accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b",
                               want.accepted, out_bus.accepted);
                        errors++;
                    end
                end
            end
            // one long hold so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && res_count >= HOLD_AT) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end else begin
                next_ready = (res_count >= 120 && res_count < 220) ||
                             $urandom_range(99) >= IDLE_PCT;
            end
            out_bus.ready <= next_ready;
        end
    end

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.mode       = mck_pkg::MODE_TICK;
        in_bus.ascii_char = 8'd0;
        out_bus.ready     = 1'b0;

        // directed: idle tick, case folding, start while busy, word space
        push_setting(16'd1);
        push_tick();
        push_item(mck_pkg::MODE_START, "e");
        push_item(mck_pkg::MODE_START, "A");
        repeat (4) push_tick();
        push_item(mck_pkg::MODE_START, " ");
        repeat (10) push_tick();
        push_tick();

        run_phase(16'd0, 90);
        run_phase(16'd2, 90);
        run_phase(16'd1, 100);
        run_phase(16'd3, 50);

        // longest unit: the character stays on its first element
        push_setting(16'hFFFF);
        push_item(mck_pkg::MODE_START, "T");
        push_item(mck_pkg::MODE_START, 8'hFF);
        repeat (40) push_tick();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (key_items.size() > 0 || in_bus.valid) @(posedge i_clk);
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
